// File: hdl/md5_pkg.sv
// ----------------------------------------------------------------------------
// MD5 package
// Shared types, initial values and round tables of the MD5 digest core.
// ----------------------------------------------------------------------------
package md5_pkg;

   localparam int BLOCK_WORDS = 16;
   localparam int WORD_IDX_W  = $clog2(BLOCK_WORDS);
   localparam int ROUNDS      = 64;
   localparam int ROUND_W     = $clog2(ROUNDS);
   localparam int BYTE_POS_W  = 6;
   localparam int COUNT_W     = 64;

   localparam logic [31:0] IV_A = 32'h6745_2301;
   localparam logic [31:0] IV_B = 32'hefcd_ab89;
   localparam logic [31:0] IV_C = 32'h98ba_dcfe;
   localparam logic [31:0] IV_D = 32'h1032_5476;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [BYTE_POS_W-1:0] LEN_POS = 6'd56;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } chain_type;

   localparam chain_type CHAIN_IV = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};

   function automatic logic [31:0] round_k(input logic [ROUND_W-1:0] r);
      logic [31:0] k;
      case (r)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = '0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [ROUND_W-1:0] r);
      logic [4:0] s;
      case ({r[5:4], r[1:0]})
         4'b0000: s = 5'd7;   4'b0001: s = 5'd12;  4'b0010: s = 5'd17;  4'b0011: s = 5'd22;
         4'b0100: s = 5'd5;   4'b0101: s = 5'd9;   4'b0110: s = 5'd14;  4'b0111: s = 5'd20;
         4'b1000: s = 5'd4;   4'b1001: s = 5'd11;  4'b1010: s = 5'd16;  4'b1011: s = 5'd23;
         4'b1100: s = 5'd6;   4'b1101: s = 5'd10;  4'b1110: s = 5'd15;  4'b1111: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   function automatic logic [WORD_IDX_W-1:0] msg_index(input logic [ROUND_W-1:0] r);
      logic [7:0] t;
      case (r[5:4])
         2'd0:    t = {4'd0, r[3:0]};
         2'd1:    t = {4'd0, r[3:0]} * 8'd5 + 8'd1;
         2'd2:    t = {4'd0, r[3:0]} * 8'd3 + 8'd5;
         default: t = {4'd0, r[3:0]} * 8'd7;
      endcase
      return t[WORD_IDX_W-1:0];
   endfunction

endpackage

// File: hdl/md5_stream_if.sv
// ----------------------------------------------------------------------------
// MD5 stream interfaces
// Valid/ready channels for message bytes and for digest results.
// ----------------------------------------------------------------------------
interface md5_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   logic       no_data;

   modport source (output valid, data_byte, last_byte, no_data, input ready);
   modport sink (input valid, data_byte, last_byte, no_data, output ready);
endinterface

interface md5_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word_a;
   logic [31:0] digest_word_b;
   logic [31:0] digest_word_c;
   logic [31:0] digest_word_d;

   modport source (output valid, digest_word_a, digest_word_b, digest_word_c,
                   digest_word_d, input ready);
   modport sink (input valid, digest_word_a, digest_word_b, digest_word_c,
                 digest_word_d, output ready);
endinterface

// File: hdl/md5_msg_buf.sv
// ----------------------------------------------------------------------------
// MD5 message buffer
// Sixteen-word block store with byte-lane writes and a registered word read.
// ----------------------------------------------------------------------------
module md5_msg_buf (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [md5_pkg::WORD_IDX_W-1:0]  wr_addr,
   input  logic [1:0]                      wr_lane,
   input  logic [7:0]                      wr_byte,
   input  logic [md5_pkg::WORD_IDX_W-1:0]  rd_addr,
   output logic [31:0]                     rd_data_ff
);
   import md5_pkg::*;

   logic [31:0] mem_ff [BLOCK_WORDS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr][8*wr_lane +: 8] <= wr_byte;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// File: hdl/md5_round.sv
// ----------------------------------------------------------------------------
// MD5 round unit
// One MD5 step: mixing function, four-way add, rotate and word shuffle.
// ----------------------------------------------------------------------------
module md5_round (
   input  logic [md5_pkg::ROUND_W-1:0] round_idx,
   input  md5_pkg::chain_type          work_in,
   input  logic [31:0]                 msg_word,
   output md5_pkg::chain_type          work_out
);
   import md5_pkg::*;

   logic [31:0] mix;
   logic [31:0] sum;
   logic [63:0] rot_wide;
   logic [4:0]  shift;

   always_comb begin
      case (round_idx[5:4])
         2'd0:    mix = (work_in.b & work_in.c) | (~work_in.b & work_in.d);
         2'd1:    mix = (work_in.b & work_in.d) | (work_in.c & ~work_in.d);
         2'd2:    mix = work_in.b ^ work_in.c ^ work_in.d;
         default: mix = work_in.c ^ (work_in.b | ~work_in.d);
      endcase
      shift      = rot_amount(round_idx);
      sum        = work_in.a + mix + round_k(round_idx) + msg_word;
      rot_wide   = {sum, sum} << shift;
      work_out.a = work_in.d;
      work_out.b = work_in.b + rot_wide[63:32];
      work_out.c = work_in.b;
      work_out.d = work_in.c;
   end

endmodule

// File: hdl/md5_message_digest_core.sv
// ----------------------------------------------------------------------------
// MD5 message digest core
// Byte-streaming MD5 with one shared round unit under a small sequencer.
// ----------------------------------------------------------------------------
// The req channel carries one message byte per transfer; last_byte ends the
// message and no_data marks a transfer without a byte, so an empty message
// is one transfer with both set. The rsp channel carries the 128-bit digest
// as four words, each read little-endian as bytes.
// The 64th byte of a block starts a compression (one buffer read, 64 rounds
// through the single round unit, one fold into the chaining words); req_ready
// is low meanwhile. The last transfer adds the padding bytes, 64 minus the
// fill of the block, then a compression, and when the length does not fit, a
// second block of 64 padding bytes and a compression.
// The digest appears in the output register right after the final fold.
// A stalled receiver does not block new bytes; only the finishing fold of
// the next message waits until the held digest has been taken.
// Reset restores the initial chaining words, clears the byte count and
// drops any pending digest. No clearing pass is needed.
// ----------------------------------------------------------------------------
module md5_message_digest_core (
   input  logic        clock,
   input  logic        reset,
   md5_req_if.sink     req_port,
   md5_rsp_if.source   rsp_port
);
   import md5_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_PRIME,
      ST_COMP,
      ST_FOLD
   } state_type;

   state_type              state_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic [COUNT_W-1:0]     count_in;
   chain_type              chain_ff;
   chain_type              work_ff;
   chain_type              work_out;
   chain_type              rsp_data_ff;
   logic                   rsp_valid_ff;
   logic [ROUND_W-1:0]     round_ff;
   logic [ROUND_W-1:0]     round_in;
   logic [BYTE_POS_W-1:0]  pad_pos_ff;
   logic                   pad_first_ff;
   logic                   len_here_ff;
   logic                   pad_pend_ff;
   logic                   final_ff;
   logic [COUNT_W-1:0]     bit_len;
   logic [7:0]             pad_byte;
   logic                   accept;
   logic                   wr_en;
   logic [WORD_IDX_W-1:0]  wr_addr;
   logic [1:0]             wr_lane;
   logic [7:0]             wr_byte;
   logic [WORD_IDX_W-1:0]  rd_addr;
   logic [31:0]            rd_data;

   assign accept   = req_port.valid && req_port.ready;
   assign round_in = round_ff + 1'b1;
   assign count_in = count_ff + {{(COUNT_W-1){1'b0}}, !req_port.no_data};
   assign bit_len  = {count_ff[COUNT_W-4:0], 3'b000};

   always_comb begin
      if (pad_first_ff) begin
         pad_byte = PAD_MARK;
      end else if (len_here_ff && pad_pos_ff >= LEN_POS) begin
         pad_byte = bit_len[8*pad_pos_ff[2:0] +: 8];
      end else begin
         pad_byte = '0;
      end
      if (state_ff == ST_PAD) begin
         wr_en   = 1'b1;
         wr_addr = pad_pos_ff[5:2];
         wr_lane = pad_pos_ff[1:0];
         wr_byte = pad_byte;
      end else begin
         wr_en   = accept && !req_port.no_data;
         wr_addr = count_ff[5:2];
         wr_lane = count_ff[1:0];
         wr_byte = req_port.data_byte;
      end
      rd_addr = (state_ff == ST_COMP) ? msg_index(round_in) : msg_index('0);
   end

   md5_msg_buf u_buf (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_lane    (wr_lane),
      .wr_byte    (wr_byte),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   md5_round u_round (
      .round_idx (round_ff),
      .work_in   (work_ff),
      .msg_word  (rd_data),
      .work_out  (work_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         chain_ff     <= CHAIN_IV;
         rsp_valid_ff <= 1'b0;
         round_ff     <= '0;
         pad_pos_ff   <= '0;
         pad_first_ff <= 1'b0;
         len_here_ff  <= 1'b0;
         pad_pend_ff  <= 1'b0;
         final_ff     <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_port.ready && !(state_ff == ST_FOLD && final_ff)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  count_ff <= count_in;
                  if (req_port.last_byte) begin
                     pad_pos_ff   <= count_in[BYTE_POS_W-1:0];
                     pad_first_ff <= 1'b1;
                     len_here_ff  <= (count_in[BYTE_POS_W-1:0] < LEN_POS);
                     pad_pend_ff  <= 1'b1;
                  end
                  if (!req_port.no_data && count_ff[BYTE_POS_W-1:0] == '1) begin
                     state_ff <= ST_PRIME;
                     final_ff <= 1'b0;
                  end else if (req_port.last_byte) begin
                     state_ff <= ST_PAD;
                  end
               end
            end
            ST_PAD: begin
               pad_pend_ff  <= (pad_pos_ff == '1) && !len_here_ff;
               pad_first_ff <= 1'b0;
               pad_pos_ff   <= pad_pos_ff + 1'b1;
               if (pad_pos_ff == '1) begin
                  state_ff <= ST_PRIME;
                  final_ff <= len_here_ff;
                  if (!len_here_ff) begin
                     len_here_ff <= 1'b1;
                  end
               end
            end
            ST_PRIME: begin
               work_ff  <= chain_ff;
               round_ff <= '0;
               state_ff <= ST_COMP;
            end
            ST_COMP: begin
               work_ff  <= work_out;
               round_ff <= round_in;
               if (round_ff == '1) begin
                  state_ff <= ST_FOLD;
               end
            end
            ST_FOLD: begin
               if (!final_ff) begin
                  chain_ff.a <= chain_ff.a + work_ff.a;
                  chain_ff.b <= chain_ff.b + work_ff.b;
                  chain_ff.c <= chain_ff.c + work_ff.c;
                  chain_ff.d <= chain_ff.d + work_ff.d;
                  state_ff   <= pad_pend_ff ? ST_PAD : ST_IDLE;
               end else if (!rsp_valid_ff || rsp_port.ready) begin
                  rsp_data_ff.a <= chain_ff.a + work_ff.a;
                  rsp_data_ff.b <= chain_ff.b + work_ff.b;
                  rsp_data_ff.c <= chain_ff.c + work_ff.c;
                  rsp_data_ff.d <= chain_ff.d + work_ff.d;
                  rsp_valid_ff  <= 1'b1;
                  chain_ff      <= CHAIN_IV;
                  count_ff      <= '0;
                  final_ff      <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_port.ready          = (state_ff == ST_IDLE);
   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.digest_word_a  = rsp_data_ff.a;
   assign rsp_port.digest_word_b  = rsp_data_ff.b;
   assign rsp_port.digest_word_c  = rsp_data_ff.c;
   assign rsp_port.digest_word_d  = rsp_data_ff.d;

endmodule

// File: hdl/md5_message_digest_checker.sv
// ----------------------------------------------------------------------------
// MD5 message digest checker
// Port-level assertions on the digest core, attached to it by a bind.
// ----------------------------------------------------------------------------
module md5_message_digest_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input logic [127:0] rsp_digest
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Digest was withdrawn before its transfer.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_digest))
      else $error("Digest changed while the receiver stalled.");

   assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid))
      else $error("Core went busy without a transfer on the request side.");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("Digest appeared in the cycle right after a request transfer.");

endmodule

bind md5_message_digest_core md5_message_digest_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_port.valid),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .rsp_digest ({rsp_port.digest_word_a, rsp_port.digest_word_b,
                 rsp_port.digest_word_c, rsp_port.digest_word_d})
);
